/* hdl/lqrf_pkg.sv */
package lqrf_pkg;

  // Field widths of the sample and result channels
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned OUT_W    = 17;
  localparam int unsigned MODE_W   = 3;

  // APB register map, word index into the register list
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_THRESHOLD    = 2'd0,
    REG_MISSING_CODE = 2'd1,
    REG_COMPARE_MODE = 2'd2
  } reg_idx_e;

  // Compare modes; codes five to seven never qualify
  typedef enum logic [MODE_W-1:0] {
    CMP_GT = 3'd0,
    CMP_GE = 3'd1,
    CMP_LT = 3'd2,
    CMP_LE = 3'd3,
    CMP_EQ = 3'd4
  } cmp_mode_e;

  // Register reset values
  localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RST    = 32'sd0;
  localparam logic signed [SAMPLE_W-1:0] MISSING_CODE_RST = 32'sd2559744;
  localparam logic [MODE_W-1:0]          COMPARE_MODE_RST = CMP_GT;

  // Result code for "no run"
  localparam logic [OUT_W-1:0] NO_INDEX = {OUT_W{1'b1}};

endpackage

/* hdl/longest_qualifying_run_finder.sv */
// A series' result is loaded into the output register when its last sample is processed.
// Throughput: one sample per cycle; the input stalls only while a finished result
// waits on a stalled output and the next registered sample also ends a series.
// Reset (rst_ni low, asynchronous) empties both stages, clears the series state
// and loads the register reset values; no clearing pass is needed.
module longest_qualifying_run_finder
  import lqrf_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 65536
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // sample channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       series_end_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic        [OUT_W-1:0]    max_length_o,
  output logic signed [OUT_W-1:0]    start_index_o,
  output logic signed [OUT_W-1:0]    end_index_o,
  output logic                       all_missing_o,
  // APB configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic        [PADDR_W-1:0]  paddr,
  input  logic        [PDATA_W-1:0]  pwdata,
  output logic        [PDATA_W-1:0]  prdata,
  output logic                       pready
);

  // Counter holds MAX_SAMPLES itself; an index stays below it
  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_SAMPLES);
  localparam int unsigned EXT_W = (CNT_W + 1 > OUT_W) ? CNT_W + 1 : OUT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  // Configuration registers
  logic signed [SAMPLE_W-1:0] threshold_q;
  logic signed [SAMPLE_W-1:0] missing_code_q;
  logic        [MODE_W-1:0]   compare_mode_q;
  logic                       cfg_write;
  reg_idx_e                   cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_idx   = reg_idx_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q    <= THRESHOLD_RST;
      missing_code_q <= MISSING_CODE_RST;
      compare_mode_q <= COMPARE_MODE_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_THRESHOLD:    threshold_q    <= pwdata;
        REG_MISSING_CODE: missing_code_q <= pwdata;
        REG_COMPARE_MODE: compare_mode_q <= pwdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (cfg_idx)
      REG_THRESHOLD:    prdata = threshold_q;
      REG_MISSING_CODE: prdata = missing_code_q;
      REG_COMPARE_MODE: prdata = {{(PDATA_W-MODE_W){1'b0}}, compare_mode_q};
      default:          prdata = '0;
    endcase
  end

  // Input register
  logic                       in_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       last_q;
  logic                       proc_go;
  logic                       in_take;

  // Output register
  logic                       out_valid_q;
  logic        [OUT_W-1:0]    max_length_q;
  logic        [OUT_W-1:0]    start_index_q;
  logic        [OUT_W-1:0]    end_index_q;
  logic                       all_missing_q;

  // Process the registered sample unless its result would overwrite a stalled one
  assign proc_go    = in_valid_q & ~(last_q & out_valid_q & out_stall_i);
  assign in_stall_o = in_valid_q & ~proc_go;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= sample_i;
      last_q   <= series_end_i;
    end
  end

  // Series state
  logic [CNT_W-1:0] time_index_q, time_index_d;
  logic [CNT_W-1:0] run_length_q, run_length_d;
  logic [IDX_W-1:0] run_start_q,  run_start_d;
  logic [CNT_W-1:0] best_length_q, best_length_d;
  logic [IDX_W-1:0] best_start_q,  best_start_d;
  logic             seen_valid_q,  seen_valid_d;

  logic             active;
  logic             not_missing;
  logic             cmp_hit;
  logic             qual;
  logic [EXT_W-1:0] end_sum;

  // Qualify the sample against the threshold
  always_comb begin
    not_missing = (sample_q != missing_code_q);
    unique case (compare_mode_q)
      CMP_GT:  cmp_hit = (sample_q >  threshold_q);
      CMP_GE:  cmp_hit = (sample_q >= threshold_q);
      CMP_LT:  cmp_hit = (sample_q <  threshold_q);
      CMP_LE:  cmp_hit = (sample_q <= threshold_q);
      CMP_EQ:  cmp_hit = (sample_q == threshold_q);
      default: cmp_hit = 1'b0;
    endcase
    qual = not_missing & cmp_hit;
  end

  // Advance current and best runs; samples past the limit are ignored
  always_comb begin
    active        = (time_index_q < CNT_MAX);
    time_index_d  = time_index_q;
    run_length_d  = run_length_q;
    run_start_d   = run_start_q;
    best_length_d = best_length_q;
    best_start_d  = best_start_q;
    seen_valid_d  = seen_valid_q;
    if (active) begin
      seen_valid_d = seen_valid_q | not_missing;
      if (qual) begin
        run_length_d = run_length_q + CNT_W'(1);
        if (run_length_q == '0) begin
          run_start_d = time_index_q[IDX_W-1:0];
        end
      end else begin
        run_length_d = '0;
      end
      if (run_length_d > best_length_q) begin
        best_length_d = run_length_d;
        best_start_d  = run_start_d;
      end
      time_index_d = time_index_q + CNT_W'(1);
    end
    end_sum = EXT_W'(best_start_d) + EXT_W'(best_length_d) - EXT_W'(1);
  end

  // Commit state; the last sample of a series clears it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_index_q  <= '0;
      run_length_q  <= '0;
      run_start_q   <= '0;
      best_length_q <= '0;
      best_start_q  <= '0;
      seen_valid_q  <= 1'b0;
    end else if (proc_go) begin
      if (last_q) begin
        time_index_q  <= '0;
        run_length_q  <= '0;
        run_start_q   <= '0;
        best_length_q <= '0;
        best_start_q  <= '0;
        seen_valid_q  <= 1'b0;
      end else begin
        time_index_q  <= time_index_d;
        run_length_q  <= run_length_d;
        run_start_q   <= run_start_d;
        best_length_q <= best_length_d;
        best_start_q  <= best_start_d;
        seen_valid_q  <= seen_valid_d;
      end
    end
  end

  // Load the result register; drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_go && last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go && last_q) begin
      max_length_q  <= OUT_W'(best_length_d);
      all_missing_q <= ~seen_valid_d;
      if (best_length_d == '0) begin
        start_index_q <= NO_INDEX;
        end_index_q   <= NO_INDEX;
      end else begin
        start_index_q <= OUT_W'(EXT_W'(best_start_d));
        end_index_q   <= end_sum[OUT_W-1:0];
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign max_length_o  = max_length_q;
  assign start_index_o = start_index_q;
  assign end_index_o   = end_index_q;
  assign all_missing_o = all_missing_q;

endmodule

/* hdl/lqrf_checker.sv */
module lqrf_checker
  import lqrf_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic        [OUT_W-1:0]    max_length_o,
  input logic signed [OUT_W-1:0]    start_index_o,
  input logic signed [OUT_W-1:0]    end_index_o,
  input logic                       all_missing_o
);

  // Hold a stalled result unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(max_length_o)
      && $stable(start_index_o) && $stable(end_index_o) && $stable(all_missing_o))
    else $error("stalled result changed");

  // An empty run reports no indices
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (max_length_o == '0) |->
      (start_index_o == NO_INDEX) && (end_index_o == NO_INDEX))
    else $error("empty run with indices");

  // An all-missing series has no run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && all_missing_o |-> (max_length_o == '0))
    else $error("all-missing series reports a run");

  // Stall requests only while a result is blocked downstream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

endmodule

bind longest_qualifying_run_finder lqrf_checker u_lqrf_checker (.*);
